/* rtl/core/atlp_pkg.sv */
// ----------------------------------------------------------------------------
// ASCII telemetry line parser package
// Character codes, parser flag types and small helper functions shared by
// the parser modules.
// ----------------------------------------------------------------------------
package atlp_pkg;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [2:0] POS_TIME = 3'd3;
    localparam logic [2:0] POS_BAD  = 3'd4;

    localparam logic [7:0] TIME_SCALE = 8'd60;

    typedef struct packed {
        logic seen;
        logic neg;
        logic point;
        logic stop;
    } parse_flags_t;

    typedef struct packed {
        logic colon;
        logic seen;
        logic neg;
        logic stop;
    } colon_flags_t;

    function automatic int frac_width(input int fd);
        return (fd == 0) ? 1 : $clog2(10 ** fd);
    endfunction

    function automatic int count_width(input int fd);
        return (fd < 2) ? 1 : $clog2(fd + 1);
    endfunction

    function automatic logic [19:0] pow10_lut(input logic [2:0] n);
        logic [19:0] p;
        case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/atlp_token_acc.sv */
// ----------------------------------------------------------------------------
// Token accumulator
// Holds the field position and the running number parsers of a token, updated
// by one character per step; carriage return clears only the parsers.
// ----------------------------------------------------------------------------
module atlp_token_acc #(
    parameter int FRACTION_DIGITS = 3,
    parameter int VALUE_BITS      = 32,
    parameter int FW              = 10,
    parameter int CW              = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              char_in,
    output logic [2:0]              pos,
    output logic [VALUE_BITS-1:0]   whole,
    output logic [VALUE_BITS-1:0]   whole_scaled,
    output logic [VALUE_BITS-1:0]   whole_x60,
    output logic [FW-1:0]           frac_scaled,
    output atlp_pkg::parse_flags_t  pflags,
    output logic [VALUE_BITS-1:0]   after_colon,
    output atlp_pkg::colon_flags_t  cflags
);
    import atlp_pkg::*;

    localparam int AW = VALUE_BITS;
    localparam int MW = AW + 25;
    localparam logic [AW-1:0] CAP = {1'b1, {(AW-1){1'b0}}};
    localparam logic [23:0] SCALE = 24'(10 ** FRACTION_DIGITS);

    logic [2:0]    pos_reg, pos_next;
    logic [AW-1:0] whole_reg, whole_next;
    logic [AW-1:0] ws_reg, ws_next;
    logic [AW-1:0] w60_reg, w60_next;
    logic [FW-1:0] fs_reg, fs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    parse_flags_t  pf_reg, pf_next;
    logic [AW-1:0] ac_reg, ac_next;
    colon_flags_t  cf_reg, cf_next;

    logic          is_digit;
    logic          is_sign;
    logic [23:0]   digit;
    logic [19:0]   place;
    logic [19:0]   frac_add;

    function automatic logic [AW-1:0] mac10(input logic [AW-1:0] acc, input logic [23:0] add);
        logic [MW-1:0] sum;
        sum = (MW'(acc) << 3) + (MW'(acc) << 1) + MW'(add);
        return (sum >= MW'(CAP)) ? CAP : sum[AW-1:0];
    endfunction

    always_comb
    begin
        is_digit = (char_in inside {[CH_ZERO:CH_NINE]});
        is_sign  = (char_in == CH_PLUS) || (char_in == CH_MINUS);
        digit    = 24'(char_in[3:0]);
        place    = pow10_lut(3'(FRACTION_DIGITS - 1) - 3'(cnt_reg));
        frac_add = 20'(place * digit[3:0]);

        pos_next   = pos_reg;
        whole_next = whole_reg;
        ws_next    = ws_reg;
        w60_next   = w60_reg;
        fs_next    = fs_reg;
        cnt_next   = cnt_reg;
        pf_next    = pf_reg;
        ac_next    = ac_reg;
        cf_next    = cf_reg;

        if (step)
        begin
            if (char_in == CH_LF)
            begin
                pos_next = '0;
            end
            else if (char_in == CH_CR)
            begin
                pos_next   = (pos_reg == POS_BAD) ? POS_BAD : 3'(pos_reg + 3'd1);
                whole_next = '0;
                ws_next    = '0;
                w60_next   = '0;
                fs_next    = '0;
                cnt_next   = '0;
                pf_next    = '0;
                ac_next    = '0;
                cf_next    = '0;
            end
            else if (char_in != CH_SPACE)
            begin
                if (!pf_reg.stop)
                begin
                    pf_next.seen = 1'b1;
                    if (is_digit)
                    begin
                        if (pf_reg.point)
                        begin
                            if (int'(cnt_reg) < FRACTION_DIGITS)
                            begin
                                fs_next  = FW'(fs_reg + FW'(frac_add));
                                cnt_next = CW'(cnt_reg + 1'b1);
                            end
                        end
                        else
                        begin
                            whole_next = mac10(whole_reg, digit);
                            ws_next    = mac10(ws_reg, 24'(digit * SCALE));
                            w60_next   = mac10(w60_reg, 24'(digit * 24'(TIME_SCALE)));
                        end
                    end
                    else if (is_sign && !pf_reg.seen)
                    begin
                        pf_next.neg = (char_in == CH_MINUS);
                    end
                    else if ((char_in == CH_POINT) && !pf_reg.point)
                    begin
                        pf_next.point = 1'b1;
                    end
                    else
                    begin
                        pf_next.stop = 1'b1;
                    end
                end

                if (!cf_reg.colon)
                begin
                    cf_next.colon = (char_in == CH_COLON);
                end
                else if (!cf_reg.stop)
                begin
                    cf_next.seen = 1'b1;
                    if (is_digit)
                    begin
                        ac_next = mac10(ac_reg, digit);
                    end
                    else if (is_sign && !cf_reg.seen)
                    begin
                        cf_next.neg = (char_in == CH_MINUS);
                    end
                    else
                    begin
                        cf_next.stop = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            whole_reg <= '0;
            ws_reg    <= '0;
            w60_reg   <= '0;
            fs_reg    <= '0;
            cnt_reg   <= '0;
            pf_reg    <= '0;
            ac_reg    <= '0;
            cf_reg    <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            whole_reg <= whole_next;
            ws_reg    <= ws_next;
            w60_reg   <= w60_next;
            fs_reg    <= fs_next;
            cnt_reg   <= cnt_next;
            pf_reg    <= pf_next;
            ac_reg    <= ac_next;
            cf_reg    <= cf_next;
        end
    end

    assign pos          = pos_reg;
    assign whole        = whole_reg;
    assign whole_scaled = ws_reg;
    assign whole_x60    = w60_reg;
    assign frac_scaled  = fs_reg;
    assign pflags       = pf_reg;
    assign after_colon  = ac_reg;
    assign cflags       = cf_reg;

endmodule

/* rtl/core/atlp_result_calc.sv */
// ----------------------------------------------------------------------------
// Result calculator
// Forms the saturated output value of the finished token from the parser
// state: thousandths for the measurement fields, seconds for the time field.
// ----------------------------------------------------------------------------
module atlp_result_calc #(
    parameter int VALUE_BITS = 32,
    parameter int FW         = 10
) (
    input  logic [2:0]              pos,
    input  logic [VALUE_BITS-1:0]   whole,
    input  logic [VALUE_BITS-1:0]   whole_scaled,
    input  logic [VALUE_BITS-1:0]   whole_x60,
    input  logic [FW-1:0]           frac_scaled,
    input  atlp_pkg::parse_flags_t  pflags,
    input  logic [VALUE_BITS-1:0]   after_colon,
    input  atlp_pkg::colon_flags_t  cflags,
    output logic [1:0]              field_index,
    output logic [31:0]             field_value,
    output logic                    bad_position
);
    import atlp_pkg::*;

    localparam int AW = VALUE_BITS;
    localparam int SW = AW + FW + 1;
    localparam int EW = ((AW > 32) ? AW : 32) + 1;
    localparam logic [AW-1:0] CAP = {1'b1, {(AW-1){1'b0}}};

    logic [SW-1:0] sum_m;
    logic [AW-1:0] mag_m;
    logic          bn;
    logic [AW-1:0] bm;
    logic [AW:0]   sum_t;
    logic [AW-1:0] mag_t;
    logic          neg_t;

    function automatic logic [31:0] to_out(input logic neg, input logic [AW-1:0] mag);
        logic [EW-1:0] ext;
        if (neg)
        begin
            ext = EW'(0) - EW'(mag);
        end
        else
        begin
            ext = (mag >= CAP) ? EW'(CAP - 1'b1) : EW'(mag);
        end
        return ext[31:0];
    endfunction

    always_comb
    begin
        sum_m = SW'(whole_scaled) + SW'(frac_scaled);
        mag_m = (sum_m >= SW'(CAP)) ? CAP : sum_m[AW-1:0];

        bn = cflags.colon ? cflags.neg : pflags.neg;
        bm = cflags.colon ? after_colon : whole;
        sum_t = (AW+1)'(whole_x60) + (AW+1)'(bm);
        if (pflags.neg == bn)
        begin
            neg_t = pflags.neg;
            mag_t = (sum_t >= (AW+1)'(CAP)) ? CAP : sum_t[AW-1:0];
        end
        else if (whole_x60 >= bm)
        begin
            neg_t = pflags.neg;
            mag_t = whole_x60 - bm;
        end
        else
        begin
            neg_t = bn;
            mag_t = bm - whole_x60;
        end

        if (pos == POS_BAD)
        begin
            field_index  = '0;
            field_value  = '0;
            bad_position = 1'b1;
        end
        else if (pos == POS_TIME)
        begin
            field_index  = pos[1:0];
            field_value  = to_out(neg_t, mag_t);
            bad_position = 1'b0;
        end
        else
        begin
            field_index  = pos[1:0];
            field_value  = to_out(pflags.neg, mag_m);
            bad_position = 1'b0;
        end
    end

endmodule

/* rtl/core/ascii_telemetry_line_parser_core.sv */
// ----------------------------------------------------------------------------
// ASCII telemetry line parser core
// Parses the serial report of an electronic load one character at a time
// and delivers one numeric field per carriage return.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (data_valid, data_ready, data_byte) takes one received
// character per transfer. Line feed restarts the field position, space is
// dropped, and carriage return closes the current token and produces one
// transfer on the result channel (result_valid, result_ready, field_index,
// field_value, bad_position). Other characters produce no result.
// A character is captured in an input register and parsed from there into
// the parser state registers; a carriage return also loads the result into
// the output register. One character is accepted every cycle unless data_ready
// falls while a carriage return waits in the input register.
// The result sits in an output register. While it waits, characters that
// produce no result are still taken; a further carriage return waits in the
// input register and data_ready falls until the result transfer completes.
// Reset clears the field position and all parser state.
// ----------------------------------------------------------------------------
module ascii_telemetry_line_parser_core #(
    parameter int FRACTION_DIGITS = 3,
    parameter int VALUE_BITS      = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [1:0]  field_index,
    output logic [31:0] field_value,
    output logic        bad_position
);
    import atlp_pkg::*;

    localparam int AW = VALUE_BITS;
    localparam int FW = frac_width(FRACTION_DIGITS);
    localparam int CW = count_width(FRACTION_DIGITS);

    logic          in_valid_reg, in_valid_next;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    index_reg;
    logic [31:0]   value_reg;
    logic          bad_reg;

    logic          in_is_cr;
    logic          step;
    logic          load_out;

    logic [2:0]    pos;
    logic [AW-1:0] whole;
    logic [AW-1:0] whole_scaled;
    logic [AW-1:0] whole_x60;
    logic [FW-1:0] frac_scaled;
    parse_flags_t  pflags;
    logic [AW-1:0] after_colon;
    colon_flags_t  cflags;

    logic [1:0]    calc_index;
    logic [31:0]   calc_value;
    logic          calc_bad;

    assign in_is_cr   = (in_byte_reg == CH_CR);
    assign step       = in_valid_reg && (!in_is_cr || !out_valid_reg || result_ready);
    assign load_out   = step && in_is_cr;
    assign data_ready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (data_ready)
        begin
            in_valid_next = data_valid;
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_ready && data_valid)
        begin
            in_byte_reg <= data_byte;
        end
        if (load_out)
        begin
            index_reg <= calc_index;
            value_reg <= calc_value;
            bad_reg   <= calc_bad;
        end
    end

    atlp_token_acc #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .VALUE_BITS      (VALUE_BITS),
        .FW              (FW),
        .CW              (CW)
    ) u_token_acc (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .char_in      (in_byte_reg),
        .pos          (pos),
        .whole        (whole),
        .whole_scaled (whole_scaled),
        .whole_x60    (whole_x60),
        .frac_scaled  (frac_scaled),
        .pflags       (pflags),
        .after_colon  (after_colon),
        .cflags       (cflags)
    );

    atlp_result_calc #(
        .VALUE_BITS (VALUE_BITS),
        .FW         (FW)
    ) u_result_calc (
        .pos          (pos),
        .whole        (whole),
        .whole_scaled (whole_scaled),
        .whole_x60    (whole_x60),
        .frac_scaled  (frac_scaled),
        .pflags       (pflags),
        .after_colon  (after_colon),
        .cflags       (cflags),
        .field_index  (calc_index),
        .field_value  (calc_value),
        .bad_position (calc_bad)
    );

    assign result_valid = out_valid_reg;
    assign field_index  = index_reg;
    assign field_value  = value_reg;
    assign bad_position = bad_reg;

    a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
        pos <= POS_BAD)
        else $error("field position beyond saturation");

    a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && bad_position |-> field_index == 2'd0 && field_value == 32'd0)
        else $error("bad position result carries data");

    a_lf_restart : assert property (@(posedge clk) disable iff (!rst_n)
        step && in_byte_reg == CH_LF |=> pos == 3'd0)
        else $error("line feed did not restart field position");

    a_cr_waits : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_is_cr && result_valid && !result_ready |=> in_valid_reg && result_valid)
        else $error("carriage return dropped while result stalled");

endmodule
